FILE: src/tlep_pkg.sv
// ----------------------------------------------------------------------------
// tlep_pkg: shared types and constants for the timestamp line entry parser
// Character codes, line geometry, result codes and the digit pair helper.
// ----------------------------------------------------------------------------
`default_nettype none

package tlep_pkg;

  // Line geometry
  localparam int unsigned LINE_LEN = 14;
  localparam int unsigned FILL_W   = $clog2(LINE_LEN + 1);

  // Character codes
  localparam logic [7:0] CH_BS    = 8'd8;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_SLASH = 8'd47;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_COLON = 8'd58;
  localparam logic [7:0] CH_TILDE = 8'd126;
  localparam logic [7:0] CH_DEL   = 8'd127;

  // Separator positions in DD/MM HH:MM:SS
  localparam int unsigned POS_SLASH  = 2;
  localparam int unsigned POS_SPACE  = 5;
  localparam int unsigned POS_COLON1 = 8;
  localparam int unsigned POS_COLON2 = 11;

  // Range limits
  localparam logic [7:0] DAY_MAX   = 8'd31;
  localparam logic [7:0] MONTH_MAX = 8'd12;
  localparam logic [7:0] HOUR_MAX  = 8'd23;
  localparam logic [7:0] MINSEC_MAX = 8'd59;

  // Result codes
  typedef enum logic [2:0] {
    EV_IGNORED = 3'd0,
    EV_ECHO    = 3'd1,
    EV_ERASED  = 3'd2,
    EV_ACCEPT  = 3'd3,
    EV_REJECT  = 3'd4
  } event_t;

  typedef logic [LINE_LEN-1:0][7:0] line_t;

  typedef struct packed {
    logic [4:0] day;
    logic [3:0] month;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } date_t;

  typedef struct packed {
    logic  ok;
    date_t date;
  } verdict_t;

  // Two ASCII characters to a value, no digit check, modulo 256
  function automatic logic [7:0] pair_value(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] hi;
    logic [7:0] lo;
    hi = a - CH_ZERO;
    lo = b - CH_ZERO;
    return (hi << 3) + (hi << 1) + lo;
  endfunction

endpackage

`default_nettype wire

FILE: src/tlep_if.sv
// ----------------------------------------------------------------------------
// tlep channel interfaces
// Valid/ready channels for received characters and for parse results.
// ----------------------------------------------------------------------------
`default_nettype none

interface tlep_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_char;

  modport source (output valid, output rx_char, input ready);
  modport sink   (input valid, input rx_char, output ready);
endinterface

interface tlep_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_res;
  logic [7:0] echo_char;
  logic [4:0] day;
  logic [3:0] month;
  logic [4:0] hour;
  logic [5:0] minute;
  logic [5:0] second;

  modport source (output valid, output event_res, output echo_char, output day,
                  output month, output hour, output minute, output second,
                  input ready);
  modport sink   (input valid, input event_res, input echo_char, input day,
                  input month, input hour, input minute, input second,
                  output ready);
endinterface

`default_nettype wire

FILE: src/tlep_line_check.sv
// ----------------------------------------------------------------------------
// tlep_line_check: format and range check of a held line
// Checks DD/MM HH:MM:SS layout, converts digit pairs and range checks them.
// ----------------------------------------------------------------------------
`default_nettype none

module tlep_line_check (
  input  tlep_pkg::line_t                      line,
  input  logic [tlep_pkg::FILL_W-1:0]          fill_count,
  input  logic                                 overflowed,
  output tlep_pkg::verdict_t                   verdict
);
  import tlep_pkg::*;

  logic       fmt_ok;
  logic       rng_ok;
  logic [7:0] v_day;
  logic [7:0] v_month;
  logic [7:0] v_hour;
  logic [7:0] v_minute;
  logic [7:0] v_second;

  // Check the layout
  assign fmt_ok = (fill_count == FILL_W'(LINE_LEN)) && !overflowed &&
                  (line[POS_SLASH] == CH_SLASH) && (line[POS_SPACE] == CH_SPACE) &&
                  (line[POS_COLON1] == CH_COLON) && (line[POS_COLON2] == CH_COLON);

  // Convert the digit pairs
  assign v_day    = pair_value(line[0],  line[1]);
  assign v_month  = pair_value(line[3],  line[4]);
  assign v_hour   = pair_value(line[6],  line[7]);
  assign v_minute = pair_value(line[9],  line[10]);
  assign v_second = pair_value(line[12], line[13]);

  // Check the ranges
  assign rng_ok = (v_day != 8'd0) && (v_day <= DAY_MAX) &&
                  (v_month != 8'd0) && (v_month <= MONTH_MAX) &&
                  (v_hour <= HOUR_MAX) && (v_minute <= MINSEC_MAX) &&
                  (v_second <= MINSEC_MAX);

  // Report fields only on accept
  always_comb begin
    verdict = '0;
    verdict.ok = fmt_ok && rng_ok;
    if (verdict.ok) begin
      verdict.date.day    = v_day[4:0];
      verdict.date.month  = v_month[3:0];
      verdict.date.hour   = v_hour[4:0];
      verdict.date.minute = v_minute[5:0];
      verdict.date.second = v_second[5:0];
    end
  end

endmodule

`default_nettype wire

FILE: src/timestamp_line_entry_parser.sv
// ----------------------------------------------------------------------------
// timestamp_line_entry_parser: terminal line editor and timestamp parser
// Path: an accepted character beat is held in the input register, and its
// result beat is then loaded into the result register, where it can be taken.
// Throughput: one character per cycle unless stalled; one result beat each.
// Reset: synchronous active low; clears fill count, overflow flag and both
// valid registers. Stored line characters are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module timestamp_line_entry_parser (
  input  logic              clk,
  input  logic              rst_n,
  tlep_in_if.sink           in_ch,
  tlep_out_if.source        out_ch
);
  import tlep_pkg::*;

  // Input stage
  logic              s1_valid_r;
  logic [7:0]        s1_char_r;
  logic              advance;

  // Line state
  line_t             line_r;
  logic [FILL_W-1:0] fill_r;
  logic [FILL_W-1:0] fill_nxt;
  logic              ovf_r;
  logic              ovf_nxt;
  logic              wr_en;

  // Result stage
  logic              out_valid_r;
  event_t            ev_r;
  event_t            ev_nxt;
  logic [7:0]        echo_r;
  logic [7:0]        echo_nxt;
  date_t             date_r;
  date_t             date_nxt;

  verdict_t          verdict;

  tlep_line_check u_check (
    .line       (line_r),
    .fill_count (fill_r),
    .overflowed (ovf_r),
    .verdict    (verdict)
  );

  // Move a beat into the result register when it is empty or being drained
  assign advance      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || advance;

  // Decode the held character
  always_comb begin
    ev_nxt   = EV_IGNORED;
    echo_nxt = '0;
    date_nxt = '0;
    fill_nxt = fill_r;
    ovf_nxt  = ovf_r;
    wr_en    = 1'b0;
    priority if (s1_char_r == CH_CR) begin
      ev_nxt   = verdict.ok ? EV_ACCEPT : EV_REJECT;
      date_nxt = verdict.date;
      fill_nxt = '0;
      ovf_nxt  = 1'b0;
    end else if (s1_char_r == CH_BS || s1_char_r == CH_DEL) begin
      if (fill_r != '0) begin
        ev_nxt   = EV_ERASED;
        fill_nxt = fill_r - 1'b1;
        ovf_nxt  = 1'b0;
      end
    end else if (s1_char_r >= CH_SPACE && s1_char_r <= CH_TILDE) begin
      ev_nxt   = EV_ECHO;
      echo_nxt = s1_char_r;
      if (fill_r < FILL_W'(LINE_LEN)) begin
        wr_en    = 1'b1;
        fill_nxt = fill_r + 1'b1;
      end else begin
        ovf_nxt  = 1'b1;
      end
    end else begin
      ev_nxt = EV_IGNORED;
    end
  end

  // Hold the input beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_char_r <= in_ch.rx_char;
    end
  end

  // Advance line state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      ovf_r  <= 1'b0;
    end else if (advance) begin
      fill_r <= fill_nxt;
      ovf_r  <= ovf_nxt;
    end
  end

  // Store the character at the fill position
  always_ff @(posedge clk) begin
    if (advance && wr_en) begin
      line_r[fill_r] <= s1_char_r;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      ev_r   <= ev_nxt;
      echo_r <= echo_nxt;
      date_r <= date_nxt;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.event_res = ev_r;
  assign out_ch.echo_char = echo_r;
  assign out_ch.day       = date_r.day;
  assign out_ch.month     = date_r.month;
  assign out_ch.hour      = date_r.hour;
  assign out_ch.minute    = date_r.minute;
  assign out_ch.second    = date_r.second;

endmodule

`default_nettype wire

FILE: src/tlep_checker.sv
// ----------------------------------------------------------------------------
// tlep_checker: port level checks for the timestamp line entry parser
// Watches the result channel and its relation to reset and accepted beats.
// ----------------------------------------------------------------------------
`default_nettype none

module tlep_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [2:0] event_res,
  input  logic [7:0] echo_char,
  input  logic [4:0] day,
  input  logic [3:0] month,
  input  logic [4:0] hour,
  input  logic [5:0] minute,
  input  logic [5:0] second
);
  import tlep_pkg::*;

  // No result right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(event_res) &&
                                   $stable(echo_char) && $stable(day)))
    else $error("stalled result beat changed");

  // Echo carries a printable character, other events carry none
  a_echo: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((event_res == EV_ECHO) ?
                   (echo_char >= CH_SPACE && echo_char <= CH_TILDE) :
                   (echo_char == 8'd0)))
    else $error("echo character inconsistent with event");

  // Date fields only on accept, and in range then
  a_date: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((event_res == EV_ACCEPT) ?
                   (day != 5'd0 && month != 4'd0 && month <= 4'd12 &&
                    hour <= 5'd23 && minute <= 6'd59 && second <= 6'd59) :
                   (day == 5'd0 && month == 4'd0 && hour == 5'd0 &&
                    minute == 6'd0 && second == 6'd0)))
    else $error("date fields inconsistent with event");

  // A full pipeline with a stalled output refuses input
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && out_valid && !out_ready) |=> (out_ready || !in_ready))
    else $error("input taken while both stages full");

endmodule

bind timestamp_line_entry_parser tlep_checker u_tlep_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .event_res (out_ch.event_res),
  .echo_char (out_ch.echo_char),
  .day       (out_ch.day),
  .month     (out_ch.month),
  .hour      (out_ch.hour),
  .minute    (out_ch.minute),
  .second    (out_ch.second)
);

`default_nettype wire
